// ===== hw/rtl/lod_pkg.sv =====
`default_nettype none

package lod_pkg;

    // Default sizes of the entity and threshold stores.
    localparam int MAX_ENTITIES_DEF = 256;
    localparam int MAX_LEVELS_DEF   = 8;

    // Field and datapath widths.
    localparam int THR_W  = 34;
    localparam int RAD_W  = 16;
    localparam int LVL_W  = 3;
    localparam int CNT_W  = 4;
    localparam int CFG_W  = 16;
    localparam int DIF_W  = 17;
    localparam int SQ_W   = 32;
    localparam int DSQ_W  = 34;
    localparam int NUM_W  = 32;
    localparam int PRD_W  = NUM_W + CFG_W;
    localparam int EFF_W  = DSQ_W + CFG_W;
    localparam int SD_W   = DSQ_W + CFG_W;
    localparam int SDK_W  = SD_W + 4;
    localparam int E100_W = EFF_W + 7;
    localparam int WIDE_W = 64;

    // Reset values of the configuration registers.
    localparam logic [CFG_W-1:0] BIAS_SQ_RST    = 16'd4096;
    localparam logic [CFG_W-1:0] FRAC_SCALE_RST = 16'd4096;
    localparam logic [CFG_W-1:0] SCREEN_THR_RST = 16'd1311;

    typedef enum logic [1:0] {
        CMD_LOAD     = 2'd0,
        CMD_REGISTER = 2'd1,
        CMD_SELECT   = 2'd2,
        CMD_NOP      = 2'd3
    } t_cmd;

    typedef enum logic [1:0] {
        CFG_MODE       = 2'd0,
        CFG_BIAS_SQ    = 2'd1,
        CFG_FRAC_SCALE = 2'd2,
        CFG_SCREEN_THR = 2'd3
    } t_cfg_idx;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_SQUARE,
        S_ENTRY,
        S_PRODUCT,
        S_SCALE,
        S_SCAN,
        S_DECIDE,
        S_DONE
    } t_state;

    // One word of the entity store.
    typedef struct packed {
        logic             valid;
        logic [CNT_W-1:0] count;
        logic [RAD_W-1:0] radius;
        logic [LVL_W-1:0] level;
    } t_entry;

    localparam int ENT_W = $bits(t_entry);

    // Control handed from the sequencer to the level picker.
    typedef struct packed {
        logic             screen_mode;
        logic [LVL_W-1:0] scan_idx;
        logic [LVL_W-1:0] target;
        logic [LVL_W-1:0] cur;
    } t_pick_ctl;

endpackage

`default_nettype wire

// ===== hw/rtl/lod_level_select_hysteresis_unit.sv =====
`default_nettype none

// Channel   Direction  Handshake                  Payload
// input     in         i_in_valid / o_in_ready    i_cmd .. i_cam_z
// output    out        o_out_valid / i_out_ready  o_level, o_changed, o_status
// config    in         i_cfg_wr_en                i_cfg_index, i_cfg_wdata
//
// Load, register and no-op commands go from acceptance straight to the done state,
// which loads the result into the output register once it is free. A select steps
// through the square, entry, product, scale, scan and decide states, the scan reading one
// threshold a cycle from the threshold memory for each of the entity's levels; a select
// on an unregistered entity ends at the entry state. After reset a clearing pass over
// every entity marks it as not registered; no transaction is accepted during it.
// One transaction is worked on at a time; a finished result waits in the output
// register while the next transaction is accepted.

module lod_level_select_hysteresis_unit #(
    parameter int MAX_ENTITIES = lod_pkg::MAX_ENTITIES_DEF,
    parameter int MAX_LEVELS   = lod_pkg::MAX_LEVELS_DEF
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_cfg_wr_en,
    input  wire logic [1:0]                        i_cfg_index,
    input  wire logic [lod_pkg::CFG_W-1:0]         i_cfg_wdata,
    input  wire logic                              i_in_valid,
    output logic                                   o_in_ready,
    input  wire logic [1:0]                        i_cmd,
    input  wire logic [7:0]                        i_entity,
    input  wire logic [2:0]                        i_level_index,
    input  wire logic [lod_pkg::THR_W-1:0]         i_data_value,
    input  wire logic [3:0]                        i_num_levels,
    input  wire logic signed [15:0]                i_obj_x,
    input  wire logic signed [15:0]                i_obj_y,
    input  wire logic signed [15:0]                i_obj_z,
    input  wire logic signed [15:0]                i_cam_x,
    input  wire logic signed [15:0]                i_cam_y,
    input  wire logic signed [15:0]                i_cam_z,
    output logic                                   o_out_valid,
    input  wire logic                              i_out_ready,
    output logic      [2:0]                        o_level,
    output logic                                   o_changed,
    output logic                                   o_status
);

    localparam int EW        = (MAX_ENTITIES > 1) ? $clog2(MAX_ENTITIES) : 1;
    localparam int TW        = $clog2(MAX_ENTITIES * MAX_LEVELS);
    localparam int LEVEL_CAP = (MAX_LEVELS < 8) ? MAX_LEVELS : 8;
    localparam logic [EW-1:0] LAST_ENT = EW'(MAX_ENTITIES - 1);
    localparam logic [lod_pkg::CNT_W-1:0] CAP_CNT = lod_pkg::CNT_W'(LEVEL_CAP);
    localparam logic [lod_pkg::CNT_W-1:0] ONE_CNT = lod_pkg::CNT_W'(1);

    lod_pkg::t_state r_state;
    lod_pkg::t_state n_state;

    // Configuration registers.
    logic                      r_screen_mode;
    logic [lod_pkg::CFG_W-1:0] r_bias_sq;
    logic [lod_pkg::CFG_W-1:0] r_frac_scale;
    logic [lod_pkg::CFG_W-1:0] r_screen_thr;

    // Captured transaction.
    logic [7:0]                r_entity;
    logic [TW-1:0]             r_thr_base;
    logic signed [lod_pkg::DIF_W-1:0] r_dx;
    logic signed [lod_pkg::DIF_W-1:0] r_dy;
    logic signed [lod_pkg::DIF_W-1:0] r_dz;

    // Select datapath.
    lod_pkg::t_entry           r_entry;
    logic [lod_pkg::SQ_W-1:0]  r_sq_x;
    logic [lod_pkg::SQ_W-1:0]  r_sq_y;
    logic [lod_pkg::SQ_W-1:0]  r_sq_z;
    logic [lod_pkg::DSQ_W-1:0] r_dsq;
    logic [lod_pkg::NUM_W-1:0] r_num;
    logic [lod_pkg::LVL_W-1:0] r_last;
    logic [lod_pkg::LVL_W-1:0] r_cur;
    logic [lod_pkg::EFF_W-1:0] r_eff;
    logic [lod_pkg::PRD_W-1:0] r_prod;
    logic [lod_pkg::SD_W-1:0]  r_sd;
    logic [lod_pkg::WIDE_W-1:0] r_lhs;
    logic [lod_pkg::SDK_W-1:0] r_sd10;
    logic [lod_pkg::SDK_W-1:0] r_sd9;
    logic [lod_pkg::E100_W-1:0] r_eff100;
    logic [lod_pkg::LVL_W-1:0] r_scan_idx;
    logic                      r_found;
    logic [lod_pkg::LVL_W-1:0] r_target;
    logic [lod_pkg::THR_W-1:0] r_thr_target;
    logic [lod_pkg::THR_W-1:0] r_thr_cur;
    logic [EW-1:0]             r_clr;

    // Result waiting for the output register.
    logic [lod_pkg::LVL_W-1:0] r_res_level;
    logic                      r_res_changed;
    logic                      r_res_status;

    // Output register.
    logic                      r_out_valid;
    logic [lod_pkg::LVL_W-1:0] r_out_level;
    logic                      r_out_changed;
    logic                      r_out_status;

    // Memory ports.
    logic                      ent_we;
    logic [EW-1:0]             ent_waddr;
    lod_pkg::t_entry           ent_wdata;
    logic [EW-1:0]             ent_raddr;
    lod_pkg::t_entry           ent_rdata;
    logic                      thr_we;
    logic [TW-1:0]             thr_waddr;
    logic [TW-1:0]             thr_raddr;
    logic [lod_pkg::THR_W-1:0] thr_rdata;

    logic                      in_acc;
    logic                      in_range;
    logic                      li_range;
    logic                      out_load;
    logic                      scan_last;
    logic [lod_pkg::CNT_W-1:0] reg_cnt;
    logic [lod_pkg::CNT_W-1:0] ent_cnt;
    logic [lod_pkg::DSQ_W-1:0] den;
    logic [lod_pkg::NUM_W-1:0] num_sel;
    logic signed [2*lod_pkg::DIF_W-1:0] prod_x;
    logic signed [2*lod_pkg::DIF_W-1:0] prod_y;
    logic signed [2*lod_pkg::DIF_W-1:0] prod_z;
    lod_pkg::t_pick_ctl        pick_ctl;
    logic                      pick_hit;
    logic [lod_pkg::LVL_W-1:0] pick_sel;

    assign in_acc    = i_in_valid && o_in_ready;
    assign in_range  = (32'(i_entity) < MAX_ENTITIES);
    assign li_range  = (32'(i_level_index) < MAX_LEVELS);
    assign out_load  = (r_state == lod_pkg::S_DONE) && (!r_out_valid || i_out_ready);
    assign scan_last = (r_scan_idx == r_last);

    // Level counts are held to the range the threshold rows can serve.
    always_comb begin
        if (i_num_levels < ONE_CNT) begin
            reg_cnt = ONE_CNT;
        end else if (i_num_levels > CAP_CNT) begin
            reg_cnt = CAP_CNT;
        end else begin
            reg_cnt = i_num_levels;
        end
        if (r_entry.count < ONE_CNT) begin
            ent_cnt = ONE_CNT;
        end else if (r_entry.count > CAP_CNT) begin
            ent_cnt = CAP_CNT;
        end else begin
            ent_cnt = r_entry.count;
        end
    end

    // A zero distance counts as a screen fraction of exactly one.
    always_comb begin
        if (r_dsq == '0) begin
            den     = lod_pkg::DSQ_W'(1);
            num_sel = lod_pkg::NUM_W'(1);
        end else begin
            den     = r_dsq;
            num_sel = r_num;
        end
    end

    assign prod_x = r_dx * r_dx;
    assign prod_y = r_dy * r_dy;
    assign prod_z = r_dz * r_dz;

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            lod_pkg::S_CLEAR: begin
                if (r_clr == LAST_ENT) begin
                    n_state = lod_pkg::S_IDLE;
                end
            end
            lod_pkg::S_IDLE: begin
                if (in_acc) begin
                    if ((lod_pkg::t_cmd'(i_cmd) == lod_pkg::CMD_SELECT) && in_range) begin
                        n_state = lod_pkg::S_SQUARE;
                    end else begin
                        n_state = lod_pkg::S_DONE;
                    end
                end
            end
            lod_pkg::S_SQUARE:  n_state = lod_pkg::S_ENTRY;
            lod_pkg::S_ENTRY: begin
                n_state = r_entry.valid ? lod_pkg::S_PRODUCT : lod_pkg::S_DONE;
            end
            lod_pkg::S_PRODUCT: n_state = lod_pkg::S_SCALE;
            lod_pkg::S_SCALE:   n_state = lod_pkg::S_SCAN;
            lod_pkg::S_SCAN: begin
                if (scan_last) begin
                    n_state = lod_pkg::S_DECIDE;
                end
            end
            lod_pkg::S_DECIDE:  n_state = lod_pkg::S_DONE;
            lod_pkg::S_DONE: begin
                if (out_load) begin
                    n_state = lod_pkg::S_IDLE;
                end
            end
            default:            n_state = lod_pkg::S_CLEAR;
        endcase
    end

    // Handshake and memory controls.
    always_comb begin
        o_in_ready = 1'b0;
        ent_we     = 1'b0;
        ent_waddr  = EW'(r_entity);
        ent_wdata  = '0;
        ent_raddr  = EW'(i_entity);
        thr_we     = 1'b0;
        thr_waddr  = TW'(32'(i_entity) * MAX_LEVELS + 32'(i_level_index));
        thr_raddr  = r_thr_base;
        case (r_state)
            lod_pkg::S_CLEAR: begin
                ent_we    = 1'b1;
                ent_waddr = r_clr;
            end
            lod_pkg::S_IDLE: begin
                o_in_ready = 1'b1;
                thr_we = in_acc && in_range && li_range
                      && (lod_pkg::t_cmd'(i_cmd) == lod_pkg::CMD_LOAD);
                ent_we = in_acc && in_range
                      && (lod_pkg::t_cmd'(i_cmd) == lod_pkg::CMD_REGISTER);
                ent_waddr = EW'(i_entity);
                ent_wdata = '{valid: 1'b1, count: reg_cnt,
                              radius: i_data_value[lod_pkg::RAD_W-1:0], level: '0};
            end
            lod_pkg::S_SCAN: begin
                thr_raddr = r_thr_base + TW'(scan_last ? r_scan_idx : r_scan_idx + 3'd1);
            end
            lod_pkg::S_DECIDE: begin
                ent_we    = 1'b1;
                ent_wdata = '{valid: 1'b1, count: r_entry.count,
                              radius: r_entry.radius, level: pick_sel};
            end
            default: begin
                ent_we = 1'b0;
            end
        endcase
    end

    // State and output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= lod_pkg::S_CLEAR;
            r_clr       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == lod_pkg::S_CLEAR) begin
                r_clr <= r_clr + EW'(1);
            end
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Configuration writes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_screen_mode <= 1'b0;
            r_bias_sq     <= lod_pkg::BIAS_SQ_RST;
            r_frac_scale  <= lod_pkg::FRAC_SCALE_RST;
            r_screen_thr  <= lod_pkg::SCREEN_THR_RST;
        end else if (i_cfg_wr_en) begin
            case (lod_pkg::t_cfg_idx'(i_cfg_index))
                lod_pkg::CFG_MODE:       r_screen_mode <= i_cfg_wdata[0];
                lod_pkg::CFG_BIAS_SQ:    r_bias_sq     <= i_cfg_wdata;
                lod_pkg::CFG_FRAC_SCALE: r_frac_scale  <= i_cfg_wdata;
                lod_pkg::CFG_SCREEN_THR: r_screen_thr  <= i_cfg_wdata;
                default:                 r_screen_mode <= r_screen_mode;
            endcase
        end
    end

    // Select datapath, one step per state.
    always_ff @(posedge i_clk) begin
        case (r_state)
            lod_pkg::S_IDLE: begin
                if (in_acc) begin
                    r_entity   <= i_entity;
                    r_thr_base <= TW'(32'(i_entity) * MAX_LEVELS);
                    r_dx <= {i_obj_x[15], i_obj_x} - {i_cam_x[15], i_cam_x};
                    r_dy <= {i_obj_y[15], i_obj_y} - {i_cam_y[15], i_cam_y};
                    r_dz <= {i_obj_z[15], i_obj_z} - {i_cam_z[15], i_cam_z};
                    r_res_level   <= '0;
                    r_res_changed <= 1'b0;
                    r_res_status  <= (lod_pkg::t_cmd'(i_cmd) == lod_pkg::CMD_SELECT)
                                  && !in_range;
                end
            end
            lod_pkg::S_SQUARE: begin
                r_entry <= ent_rdata;
                r_sq_x  <= prod_x[lod_pkg::SQ_W-1:0];
                r_sq_y  <= prod_y[lod_pkg::SQ_W-1:0];
                r_sq_z  <= prod_z[lod_pkg::SQ_W-1:0];
            end
            lod_pkg::S_ENTRY: begin
                r_res_status <= !r_entry.valid;
                r_last <= lod_pkg::LVL_W'(ent_cnt - ONE_CNT);
                r_cur  <= (lod_pkg::CNT_W'(r_entry.level) >= ent_cnt)
                        ? lod_pkg::LVL_W'(ent_cnt - ONE_CNT) : r_entry.level;
                r_dsq  <= lod_pkg::DSQ_W'(r_sq_x) + lod_pkg::DSQ_W'(r_sq_y)
                        + lod_pkg::DSQ_W'(r_sq_z);
                r_num  <= lod_pkg::NUM_W'(r_entry.radius) * lod_pkg::NUM_W'(r_entry.radius);
            end
            lod_pkg::S_PRODUCT: begin
                r_eff  <= lod_pkg::EFF_W'(r_dsq) * lod_pkg::EFF_W'(r_bias_sq);
                r_prod <= lod_pkg::PRD_W'(num_sel) * lod_pkg::PRD_W'(r_frac_scale);
                r_sd   <= lod_pkg::SD_W'(den) * lod_pkg::SD_W'(r_screen_thr);
            end
            lod_pkg::S_SCALE: begin
                // The screen side is scaled by 65536 * 128 * 10 over Q4.12.
                r_lhs    <= (lod_pkg::WIDE_W'(r_prod) << 14) + (lod_pkg::WIDE_W'(r_prod) << 12);
                r_sd10   <= (lod_pkg::SDK_W'(r_sd) << 3) + (lod_pkg::SDK_W'(r_sd) << 1);
                r_sd9    <= (lod_pkg::SDK_W'(r_sd) << 3) + lod_pkg::SDK_W'(r_sd);
                r_eff100 <= lod_pkg::E100_W'(r_eff) * lod_pkg::E100_W'(100);
                r_scan_idx <= '0;
                r_found    <= 1'b0;
            end
            lod_pkg::S_SCAN: begin
                if (r_scan_idx == r_cur) begin
                    r_thr_cur <= thr_rdata;
                end
                if (!r_found) begin
                    if (scan_last || pick_hit) begin
                        r_found      <= 1'b1;
                        r_target     <= r_scan_idx;
                        r_thr_target <= thr_rdata;
                    end
                end
                if (!scan_last) begin
                    r_scan_idx <= r_scan_idx + 3'd1;
                end
            end
            lod_pkg::S_DECIDE: begin
                r_res_level   <= pick_sel;
                r_res_changed <= (pick_sel != r_cur);
                r_res_status  <= 1'b0;
            end
            default: begin
                r_found <= r_found;
            end
        endcase
    end

    // Output payload.
    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out_level   <= r_res_level;
            r_out_changed <= r_res_changed;
            r_out_status  <= r_res_status;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_level     = r_out_level;
    assign o_changed   = r_out_changed;
    assign o_status    = r_out_status;

    // Control for the level picker.
    assign pick_ctl = '{screen_mode: r_screen_mode, scan_idx: r_scan_idx,
                        target: r_target, cur: r_cur};

    lod_ram #(
        .WIDTH (lod_pkg::ENT_W),
        .DEPTH (MAX_ENTITIES),
        .AW    (EW)
    ) u_ent_ram (
        .i_clk   (i_clk),
        .i_we    (ent_we),
        .i_waddr (ent_waddr),
        .i_wdata (ent_wdata),
        .i_raddr (ent_raddr),
        .o_rdata (ent_rdata)
    );

    lod_ram #(
        .WIDTH (lod_pkg::THR_W),
        .DEPTH (MAX_ENTITIES * MAX_LEVELS),
        .AW    (TW)
    ) u_thr_ram (
        .i_clk   (i_clk),
        .i_we    (thr_we),
        .i_waddr (thr_waddr),
        .i_wdata (i_data_value),
        .i_raddr (thr_raddr),
        .o_rdata (thr_rdata)
    );

    lod_pick u_pick (
        .i_ctl        (pick_ctl),
        .i_thr_scan   (thr_rdata),
        .i_thr_target (r_thr_target),
        .i_thr_cur    (r_thr_cur),
        .i_eff        (r_eff),
        .i_eff100     (r_eff100),
        .i_lhs        (r_lhs),
        .i_sd         (r_sd),
        .i_sd10       (r_sd10),
        .i_sd9        (r_sd9),
        .o_hit        (pick_hit),
        .o_sel        (pick_sel)
    );

endmodule

`default_nettype wire

// ===== hw/rtl/lod_ram.sv =====
`default_nettype none

module lod_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // One write port and one registered read port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

// ===== hw/rtl/lod_pick.sv =====
`default_nettype none

module lod_pick (
    input  wire lod_pkg::t_pick_ctl                i_ctl,
    input  wire logic [lod_pkg::THR_W-1:0]         i_thr_scan,
    input  wire logic [lod_pkg::THR_W-1:0]         i_thr_target,
    input  wire logic [lod_pkg::THR_W-1:0]         i_thr_cur,
    input  wire logic [lod_pkg::EFF_W-1:0]         i_eff,
    input  wire logic [lod_pkg::E100_W-1:0]        i_eff100,
    input  wire logic [lod_pkg::WIDE_W-1:0]        i_lhs,
    input  wire logic [lod_pkg::SD_W-1:0]          i_sd,
    input  wire logic [lod_pkg::SDK_W-1:0]         i_sd10,
    input  wire logic [lod_pkg::SDK_W-1:0]         i_sd9,
    output logic                                   o_hit,
    output logic      [lod_pkg::LVL_W-1:0]         o_sel
);

    localparam logic [lod_pkg::LVL_W-1:0] TOP_LVL = '1;

    logic [lod_pkg::WIDE_W-1:0] scan_rhs;
    logic [lod_pkg::WIDE_W-1:0] far_lim;
    logic [lod_pkg::WIDE_W-1:0] near_lim;
    logic [lod_pkg::WIDE_W-1:0] up_lim;
    logic [lod_pkg::WIDE_W-1:0] dn_lim;
    logic [lod_pkg::WIDE_W-1:0] eff100_w;
    logic                       finer;
    logic                       coarser;
    logic                       keep;

    // Threshold test for the level under scan.
    always_comb begin
        scan_rhs = lod_pkg::WIDE_W'(i_sd10) << (TOP_LVL - i_ctl.scan_idx);
        if (i_ctl.screen_mode) begin
            o_hit = (i_lhs >= scan_rhs);
        end else begin
            o_hit = (i_eff < lod_pkg::EFF_W'({i_thr_scan, 12'd0}));
        end
    end

    // Hysteresis: keep the current level unless the margin is passed.
    always_comb begin
        eff100_w = lod_pkg::WIDE_W'(i_eff100);
        far_lim  = lod_pkg::WIDE_W'({i_thr_target, 12'd0}) * 64'd81;
        near_lim = lod_pkg::WIDE_W'({i_thr_cur, 12'd0}) * 64'd121;
        up_lim   = (lod_pkg::WIDE_W'(i_sd10) << (TOP_LVL - i_ctl.target))
                 + (lod_pkg::WIDE_W'(i_sd) << (TOP_LVL - i_ctl.cur));
        dn_lim   = lod_pkg::WIDE_W'(i_sd9) << (TOP_LVL - i_ctl.cur);
        finer    = (i_ctl.target < i_ctl.cur);
        coarser  = (i_ctl.target > i_ctl.cur);
        if (i_ctl.screen_mode) begin
            keep = (finer && (i_lhs < up_lim)) || (coarser && (i_lhs > dn_lim));
        end else begin
            keep = (finer && (eff100_w > far_lim)) || (coarser && (eff100_w < near_lim));
        end
        o_sel = keep ? i_ctl.cur : i_ctl.target;
    end

endmodule

`default_nettype wire

// ===== hw/rtl/lod_checker.sv =====
`default_nettype none

module lod_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        i_in_valid,
    input wire logic        o_in_ready,
    input wire logic        o_out_valid,
    input wire logic        i_out_ready,
    input wire logic [2:0]  o_level,
    input wire logic        o_changed,
    input wire logic        o_status
);

    // A stalled result holds its payload.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=> (o_out_valid && $stable(o_level)
            && $stable(o_changed) && $stable(o_status)))
        else $error("result changed while stalled");

    // An unregistered entity answers with level 0 and no change.
    a_err_payload: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_status) |-> (o_level == 3'd0 && !o_changed))
        else $error("error result carries a level");

    // One transaction at a time: acceptance closes the input.
    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> !o_in_ready)
        else $error("second transaction accepted while busy");

    // Reset starts the clearing pass with nothing pending.
    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> (!o_in_ready && !o_out_valid))
        else $error("ready or valid after reset");

endmodule

bind lod_level_select_hysteresis_unit lod_checker u_lod_checker (.*);

`default_nettype wire

// ===== dv/testbench.sv =====
`timescale 1ns / 1ps

module testbench;

    // Input transaction as offered to the block.
    typedef struct {
        lod_pkg::t_cmd              cmd;
        logic [7:0]                 ent;
        logic [2:0]                 lvl_idx;
        logic [lod_pkg::THR_W-1:0]  data;
        logic [3:0]                 nlev;
        logic signed [15:0]         ox, oy, oz, cx, cy, cz;
    } t_lod_req;

    // Result transaction expected from the block.
    typedef struct {
        logic [2:0] level;
        logic       changed;
        logic       status;
    } t_lod_res;

    logic                      i_clk = 1'b0;
    logic                      i_rst_n = 1'b0;
    logic                      i_cfg_wr_en = 1'b0;
    logic [1:0]                i_cfg_index = lod_pkg::CFG_MODE;
    logic [lod_pkg::CFG_W-1:0] i_cfg_wdata = '0;
    logic                      i_in_valid = 1'b0;
    logic                      o_in_ready;
    logic [1:0]                i_cmd = lod_pkg::CMD_NOP;
    logic [7:0]                i_entity = '0;
    logic [2:0]                i_level_index = '0;
    logic [lod_pkg::THR_W-1:0] i_data_value = '0;
    logic [3:0]                i_num_levels = '0;
    logic signed [15:0]        i_obj_x = '0, i_obj_y = '0, i_obj_z = '0;
    logic signed [15:0]        i_cam_x = '0, i_cam_y = '0, i_cam_z = '0;
    logic                      o_out_valid;
    logic                      i_out_ready = 1'b0;
    logic [2:0]                o_level;
    logic                      o_changed;
    logic                      o_status;

    lod_level_select_hysteresis_unit u_top (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_wr_en(i_cfg_wr_en), .i_cfg_index(i_cfg_index), .i_cfg_wdata(i_cfg_wdata),
        .i_in_valid(i_in_valid), .o_in_ready(o_in_ready),
        .i_cmd(i_cmd), .i_entity(i_entity), .i_level_index(i_level_index),
        .i_data_value(i_data_value), .i_num_levels(i_num_levels),
        .i_obj_x(i_obj_x), .i_obj_y(i_obj_y), .i_obj_z(i_obj_z),
        .i_cam_x(i_cam_x), .i_cam_y(i_cam_y), .i_cam_z(i_cam_z),
        .o_out_valid(o_out_valid), .i_out_ready(i_out_ready),
        .o_level(o_level), .o_changed(o_changed), .o_status(o_status)
    );

    // Clock with a 4 ns period.
    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // Shadow copy of the entity tables and configuration.
    logic [lod_pkg::THR_W-1:0] thr_mem [0:2047];
    logic [7:0]       thr_loaded [0:255];
    logic [3:0]       cnt_mem [0:255];
    logic [15:0]      rad_mem [0:255];
    logic [2:0]       lvl_mem [0:255];
    logic             ent_valid [0:255];
    int               ent_scale [0:255];
    logic             mode_screen = 1'b0;
    logic [15:0]      bias_sq = lod_pkg::BIAS_SQ_RST;
    logic [15:0]      frac_scale = lod_pkg::FRAC_SCALE_RST;
    logic [15:0]      screen_thr = lod_pkg::SCREEN_THR_RST;

    t_lod_res exp_results [$];
    int       err_count = 0;
    int       tx_idle_pct = 0;
    int       rx_idle_pct = 0;
    int       stall_req = 0;
    int       stall_ack = 0;
    int       stall_left = 0;

    initial begin
        for (int e = 0; e < 256; e++) begin
            ent_valid[e]  = 1'b0;
            thr_loaded[e] = '0;
            ent_scale[e]  = 1000;
        end
    end

    task automatic report_mismatch(input string what, input int exp_v, input int got_v);
        $display("MISMATCH %s: expected %0d got %0d at %0t", what, exp_v, got_v, $realtime);
        err_count++;
    endtask

    // Works out the level for a select on a registered entity.
    function automatic logic [2:0] select_level(input int e, input int cnt, input int cur,
                                                input longint unsigned dsq);
        longint unsigned eff, num, den, lhs, sd, k, t0;
        int              target;
        bit              hit;
        target = cnt - 1;
        hit    = 1'b0;
        if (!mode_screen) begin
            eff = dsq * bias_sq;
            for (int i = 0; i + 1 < cnt && !hit; i++) begin
                t0 = longint'(thr_mem[e*8+i]) << 12;
                if (eff < t0) begin
                    target = i;
                    hit    = 1'b1;
                end
            end
            if (target < cur) begin
                if (eff * 100 > (longint'(thr_mem[e*8+target]) << 12) * 81)
                    target = cur;
            end else if (target > cur) begin
                if (eff * 100 < (longint'(thr_mem[e*8+cur]) << 12) * 121)
                    target = cur;
            end
        end else begin
            // A zero distance counts as a full screen.
            if (dsq == 0) begin
                num = 1;
                den = 1;
            end else begin
                num = longint'(rad_mem[e]) * longint'(rad_mem[e]);
                den = dsq;
            end
            lhs = num * frac_scale * 16 * 1280;
            sd  = longint'(screen_thr) * den;
            for (int i = 0; i + 1 < cnt && !hit; i++) begin
                if (lhs >= sd * (10 * (1 << (7 - i)))) begin
                    target = i;
                    hit    = 1'b1;
                end
            end
            if (target < cur) begin
                k = 10 * (1 << (7 - target)) + (1 << (7 - cur));
                if (lhs < sd * k)
                    target = cur;
            end else if (target > cur) begin
                if (lhs > sd * (9 * (1 << (7 - cur))))
                    target = cur;
            end
        end
        return 3'(target);
    endfunction

    // Updates the shadow tables for one accepted transaction and queues its result.
    task automatic predict_result(input t_lod_req r);
        t_lod_res         res;
        int               e, cnt, cur, n;
        longint           dx, dy, dz;
        longint unsigned  dsq;
        res = '{level: 3'd0, changed: 1'b0, status: 1'b0};
        e   = r.ent;
        case (r.cmd)
            lod_pkg::CMD_LOAD: begin
                thr_mem[e*8 + r.lvl_idx] = r.data;
                thr_loaded[e][r.lvl_idx] = 1'b1;
            end
            lod_pkg::CMD_REGISTER: begin
                n = r.nlev;
                if (n < 1) n = 1;
                if (n > 8) n = 8;
                cnt_mem[e]   = 4'(n);
                rad_mem[e]   = r.data[15:0];
                lvl_mem[e]   = 3'd0;
                ent_valid[e] = 1'b1;
            end
            lod_pkg::CMD_SELECT: begin
                if (!ent_valid[e]) begin
                    res.status = 1'b1;
                end else begin
                    cnt = cnt_mem[e];
                    cur = lvl_mem[e];
                    if (cur >= cnt) cur = cnt - 1;
                    dx  = longint'(r.ox) - longint'(r.cx);
                    dy  = longint'(r.oy) - longint'(r.cy);
                    dz  = longint'(r.oz) - longint'(r.cz);
                    dsq = dx*dx + dy*dy + dz*dz;
                    res.level   = select_level(e, cnt, cur, dsq);
                    res.changed = (int'(res.level) != cur);
                    lvl_mem[e]  = res.level;
                end
            end
            default: ;
        endcase
        exp_results.push_back(res);
    endtask

    // Offers one transaction, with random idle cycles first, and waits for acceptance.
    task automatic send_item(input t_lod_req r);
        while ($urandom_range(99) < tx_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_cmd         <= r.cmd;
        i_entity      <= r.ent;
        i_level_index <= r.lvl_idx;
        i_data_value  <= r.data;
        i_num_levels  <= r.nlev;
        i_obj_x <= r.ox; i_obj_y <= r.oy; i_obj_z <= r.oz;
        i_cam_x <= r.cx; i_cam_y <= r.cy; i_cam_z <= r.cz;
        i_in_valid    <= 1'b1;
        do @(posedge i_clk); while (!o_in_ready);
        predict_result(r);
    endtask

    // Lowers valid and waits until every result is back and the block has settled.
    task automatic wait_idle();
        i_in_valid <= 1'b0;
        while (exp_results.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
    endtask

    task automatic write_cfg(input lod_pkg::t_cfg_idx idx, input logic [15:0] val);
        i_cfg_wr_en <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_wdata <= val;
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b0;
        case (idx)
            lod_pkg::CFG_MODE:       mode_screen = val[0];
            lod_pkg::CFG_BIAS_SQ:    bias_sq     = val;
            lod_pkg::CFG_FRAC_SCALE: frac_scale  = val;
            default:                 screen_thr  = val;
        endcase
        @(posedge i_clk);
    endtask

    function automatic t_lod_req make_req(input lod_pkg::t_cmd c, input int e);
        t_lod_req r;
        r.cmd = c; r.ent = 8'(e); r.lvl_idx = 3'($urandom); r.data = {2'($urandom), $urandom};
        r.nlev = 4'($urandom);
        r.ox = 16'($urandom); r.oy = 16'($urandom); r.oz = 16'($urandom);
        r.cx = 16'($urandom); r.cy = 16'($urandom); r.cz = 16'($urandom);
        return r;
    endfunction

    // A select is only issued once every threshold of a registered entity is loaded.
    function automatic t_lod_req guard_select(input t_lod_req r);
        if (r.cmd == lod_pkg::CMD_SELECT && ent_valid[r.ent] && thr_loaded[r.ent] != 8'hFF)
            r.cmd = lod_pkg::CMD_NOP;
        return r;
    endfunction

    // Loads a full threshold ladder for an entity and then registers it.
    task automatic setup_entity(input int e);
        t_lod_req r;
        int       sc;
        sc = $urandom_range(100, 18000);
        ent_scale[e] = sc;
        for (int i = 0; i < 8; i++) begin
            r = make_req(lod_pkg::CMD_LOAD, e);
            r.lvl_idx = 3'(i);
            if ($urandom_range(9) == 0)
                r.data = {2'($urandom), $urandom};
            else
                r.data = lod_pkg::THR_W'((sc * (i + 1) / 8) * (sc * (i + 1) / 8)
                                         + $urandom_range(0, sc));
            send_item(r);
        end
        r = make_req(lod_pkg::CMD_REGISTER, e);
        r.nlev = ($urandom_range(9) == 0) ? 4'($urandom) : 4'($urandom_range(1, 8));
        if ($urandom_range(3) != 0)
            r.data[15:0] = 16'($urandom_range(0, sc / 3));
        send_item(r);
    endtask

    // A select near an entity's threshold range, centred on a random camera.
    task automatic send_near_select(input int e);
        t_lod_req r;
        int       sc;
        sc = ent_scale[e];
        r = make_req(lod_pkg::CMD_SELECT, e);
        r.cx = 16'($urandom_range(0, 16000) - 8000);
        r.cy = 16'($urandom_range(0, 16000) - 8000);
        r.cz = 16'($urandom_range(0, 16000) - 8000);
        if ($urandom_range(19) == 0) begin
            r.ox = r.cx; r.oy = r.cy; r.oz = r.cz;
        end else begin
            r.ox = 16'(int'(r.cx) + $urandom_range(0, 2*sc) - sc);
            r.oy = 16'(int'(r.cy) + $urandom_range(0, 2*sc) - sc);
            r.oz = 16'(int'(r.cz) + $urandom_range(0, 2*sc) - sc);
        end
        send_item(guard_select(r));
    endtask

    // Mostly well-formed ladders and selects on a small pool, with some noise.
    task automatic run_random(input int n_items);
        int k, e;
        k = 0;
        while (k < n_items) begin
            e = $urandom_range(0, 15);
            k = $urandom_range(99);
            if (k < 8) begin
                send_item(guard_select(make_req(lod_pkg::t_cmd'($urandom_range(0, 3)),
                                                $urandom_range(0, 255))));
                k = 1;
            end else if (k < 14 || !ent_valid[e]) begin
                setup_entity(e);
                k = 9;
            end else begin
                send_near_select(e);
                k = 1;
            end
            n_items -= k;
            k = 0;
        end
    endtask

    // Reset values, command kinds, field extremes and the named corner cases.
    task automatic test_directed();
        t_lod_req r;
        r = make_req(lod_pkg::CMD_NOP, 3);
        send_item(r);
        r = make_req(lod_pkg::CMD_SELECT, 200);
        send_item(r);
        for (int i = 0; i < 8; i++) begin
            r = make_req(lod_pkg::CMD_LOAD, 0);
            r.lvl_idx = 3'(i);
            r.data = (i == 0) ? '0 : lod_pkg::THR_W'(i) * 34'd1000000;
            send_item(r);
            r.ent = 8'd255;
            r.data = '1;
            send_item(r);
        end
        r = make_req(lod_pkg::CMD_REGISTER, 0);
        r.nlev = 4'd0;
        send_item(r);
        r = make_req(lod_pkg::CMD_REGISTER, 255);
        r.nlev = 4'd15;
        r.data = '1;
        send_item(r);
        r = make_req(lod_pkg::CMD_SELECT, 255);
        r.ox = 16'sh8000; r.oy = 16'sh8000; r.oz = 16'sh8000;
        r.cx = 16'sh7FFF; r.cy = 16'sh7FFF; r.cz = 16'sh7FFF;
        send_item(r);
        r.ox = r.cx; r.oy = r.cy; r.oz = r.cz;
        send_item(r);
        r.ent = 8'd0;
        send_item(r);
        wait_idle();
        write_cfg(lod_pkg::CFG_MODE, 16'd1);
        r.ent = 8'd255;
        send_item(r);
        r.ox = 16'sh8000;
        send_item(r);
        wait_idle();
        write_cfg(lod_pkg::CFG_MODE, 16'd0);
    endtask

    task automatic test_distance_mode();
        tx_idle_pct = 35;
        rx_idle_pct = 87;
        write_cfg(lod_pkg::CFG_BIAS_SQ, 16'($urandom_range(3000, 6000)));
        run_random(350);
        wait_idle();
        write_cfg(lod_pkg::CFG_BIAS_SQ, 16'hFFFF);
        run_random(60);
        wait_idle();
        write_cfg(lod_pkg::CFG_BIAS_SQ, 16'h0000);
        run_random(60);
        wait_idle();
    endtask

    task automatic test_screen_mode();
        tx_idle_pct = 87;
        rx_idle_pct = 35;
        write_cfg(lod_pkg::CFG_MODE, 16'd1);
        write_cfg(lod_pkg::CFG_FRAC_SCALE, 16'($urandom_range(3000, 6000)));
        write_cfg(lod_pkg::CFG_SCREEN_THR, 16'($urandom_range(600, 3000)));
        run_random(350);
        wait_idle();
        write_cfg(lod_pkg::CFG_FRAC_SCALE, 16'hFFFF);
        write_cfg(lod_pkg::CFG_SCREEN_THR, 16'hFFFF);
        run_random(60);
        wait_idle();
        write_cfg(lod_pkg::CFG_FRAC_SCALE, 16'h0000);
        write_cfg(lod_pkg::CFG_SCREEN_THR, 16'h0000);
        run_random(60);
        wait_idle();
    endtask

    // Long receiver hold-off so the block backs up, then a full drain pause.
    task automatic test_backpressure();
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        write_cfg(lod_pkg::CFG_MODE, 16'd0);
        write_cfg(lod_pkg::CFG_BIAS_SQ, lod_pkg::BIAS_SQ_RST);
        stall_req <= stall_req + 1;
        run_random(80);
        i_in_valid <= 1'b0;
        while (exp_results.size() != 0) @(posedge i_clk);
        run_random(300);
        wait_idle();
        write_cfg(lod_pkg::CFG_MODE, 16'd1);
        write_cfg(lod_pkg::CFG_FRAC_SCALE, lod_pkg::FRAC_SCALE_RST);
        write_cfg(lod_pkg::CFG_SCREEN_THR, lod_pkg::SCREEN_THR_RST);
        run_random(260);
        wait_idle();
    endtask

    // Receiver: random ready, with an occasional long hold-off.
    always @(posedge i_clk) begin
        if (stall_req != stall_ack) begin
            stall_ack  = stall_req;
            stall_left = 400;
        end
        if (stall_left > 0) begin
            stall_left--;
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= ($urandom_range(99) >= rx_idle_pct);
        end
    end

    // Result checker: each output transaction against the oldest expectation.
    always @(posedge i_clk) begin
        t_lod_res e;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (exp_results.size() == 0) begin
                report_mismatch("unexpected result", 0, 1);
            end else begin
                e = exp_results.pop_front();
                if (o_level !== e.level)     report_mismatch("level", e.level, o_level);
                if (o_changed !== e.changed) report_mismatch("changed", e.changed, o_changed);
                if (o_status !== e.status)   report_mismatch("status", e.status, o_status);
            end
        end
    end

    initial begin
        #2_000_000;
        $display("lod_level_select_hysteresis_unit test failed");
        $finish;
    end

    initial begin
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_distance_mode();
        test_screen_mode();
        test_backpressure();
        wait_idle();
        if (err_count == 0)
            $display("lod_level_select_hysteresis_unit test passed");
        else
            $display("lod_level_select_hysteresis_unit test failed");
        $finish;
    end

endmodule
